// ===== rtl/esg_pkg.sv =====
package esg_pkg;

  localparam int OPERAND_BITS_DEF = 31;
  localparam int CFG_INDEX_BITS   = 2;

  // Register indexes of the configuration port
  localparam logic [CFG_INDEX_BITS-1:0] REG_PRIME     = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_GENERATOR = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PRIVATE   = 2'd2;

  // Reset values, cut to the operand width where used
  localparam logic [63:0] PRIME_RESET     = 64'd2147483647;
  localparam logic [63:0] GENERATOR_RESET = 64'd7;
  localparam logic [63:0] PRIVATE_RESET   = 64'd1;

  // Status of the shared divider
  typedef struct packed {
    logic busy;
    logic done;
  } esg_div_stat_t;

  // Sequencer states, one-hot
  typedef enum logic [25:0] {
    S_IDLE      = 26'd1 << 0,
    S_GCD       = 26'd1 << 1,
    S_GCD_RET   = 26'd1 << 2,
    S_INV_START = 26'd1 << 3,
    S_INV_R0    = 26'd1 << 4,
    S_INV_LOOP  = 26'd1 << 5,
    S_INV_Q     = 26'd1 << 6,
    S_INV_UPD   = 26'd1 << 7,
    S_INV_FIN   = 26'd1 << 8,
    S_POW_START = 26'd1 << 9,
    S_POW_B     = 26'd1 << 10,
    S_POW_STEP  = 26'd1 << 11,
    S_POW_ACC   = 26'd1 << 12,
    S_POW_SQ    = 26'd1 << 13,
    S_POW_BS    = 26'd1 << 14,
    S_POW_DONE  = 26'd1 << 15,
    S_XR0       = 26'd1 << 16,
    S_XR1       = 26'd1 << 17,
    S_XR2       = 26'd1 << 18,
    S_XR3       = 26'd1 << 19,
    S_SD        = 26'd1 << 20,
    S_SF        = 26'd1 << 21,
    S_MUL       = 26'd1 << 22,
    S_DIV_GO    = 26'd1 << 23,
    S_DIV_WAIT  = 26'd1 << 24,
    S_OUT       = 26'd1 << 25
  } esg_state_t;

endpackage

// ===== rtl/esg_div.sv =====
module esg_div
  import esg_pkg::*;
#(
  parameter int W = OPERAND_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [2*W-1:0]   dividend,
  input  logic [W-1:0]     divisor,
  output logic [2*W-1:0]   quotient,
  output logic [W-1:0]     remainder,
  output esg_div_stat_t    stat
);

  localparam int CW = $clog2(2*W + 1);

  logic [W:0]     rem;
  logic [2*W-1:0] shq;
  logic [W-1:0]   dsr;
  logic [CW-1:0]  cnt;
  logic           busy;
  logic           done;
  logic [W:0]     trial;
  logic           fits;

  // Shift in the next dividend bit and try the subtract
  assign trial = {rem[W-1:0], shq[2*W-1]};
  assign fits  = trial >= {1'b0, dsr};

  // Restoring division, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        shq  <= dividend;
        dsr  <= divisor;
      end else if (busy) begin
        rem <= fits ? (trial - {1'b0, dsr}) : trial;
        shq <= {shq[2*W-2:0], fits};
        cnt <= cnt + 1'b1;
        if (cnt == CW'(2*W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient  = shq;
  assign remainder = rem[W-1:0];
  assign stat      = '{busy: busy, done: done};

endmodule

// ===== rtl/elgamal_signature_signer_unit.sv =====
// ElGamal signer: one word in (message, nonce), one word out (public key, r, s,
// nonce_rejected). Items are taken one at a time; in_stall stays high from
// acceptance until the result word has been taken. Every modular reduction,
// division and quotient step runs through one restoring divider that yields a
// bit per cycle; a product is formed in a register ahead of its reduction. An
// item's run time grows with the Euclid step counts of the gcd check and the
// inverse and with the number of one bits in the private key and the nonce.
// A nonce rejected by the gcd check finishes after the gcd loop alone.
// Configuration writes take effect at once; the user makes them only while
// the block is idle, and the block itself does not enforce this.
module elgamal_signature_signer_unit
  import esg_pkg::*;
#(
  parameter int OPERAND_BITS = OPERAND_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [OPERAND_BITS-1:0]   cfg_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [OPERAND_BITS-1:0]   message_value,
  input  logic [OPERAND_BITS-1:0]   nonce_value,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [OPERAND_BITS-1:0]   public_key,
  output logic [OPERAND_BITS-1:0]   sig_r,
  output logic [OPERAND_BITS-1:0]   sig_s,
  output logic                      nonce_rejected
);

  localparam int N  = OPERAND_BITS;
  localparam int CW = $clog2(N + 1);

  // Configuration registers
  logic [N-1:0] prime;
  logic [N-1:0] gen;
  logic [N-1:0] priv;

  // Sequencer and working registers
  esg_state_t          state;
  esg_state_t          ret;
  logic [N-1:0]        msg;
  logic [N-1:0]        nonce;
  logic [N-1:0]        n_mod;
  logic [N-1:0]        a;
  logic [N-1:0]        b;
  logic signed [N+1:0] c0;
  logic signed [N+1:0] c1;
  logic signed [2*N+3:0] sprod;
  logic [N-1:0]        kinv;
  logic [N-1:0]        acc;
  logic [N-1:0]        base;
  logic [CW-1:0]       cnt;
  logic                sel_r;
  logic [N-1:0]        mul_a;
  logic [N-1:0]        mul_b;
  logic [2*N-1:0]      dvd;
  logic [N-1:0]        dsr;

  // Divider hookup
  logic [2*N-1:0]      quot;
  logic [N-1:0]        rem;
  esg_div_stat_t       div_stat;

  // Combinational helpers
  logic [N-1:0]        expo;
  logic signed [N+1:0] inv_t;
  logic [N-1:0]        kinv_v;
  logic [N:0]          sd_sum;
  logic [N-1:0]        sd_diff;

  esg_div #(.W(N)) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (state == S_DIV_GO),
    .dividend  (dvd),
    .divisor   (dsr),
    .quotient  (quot),
    .remainder (rem),
    .stat      (div_stat)
  );

  // Pick the exponent, fold the inverse into range, form m - x*r mod n
  always_comb begin
    expo    = sel_r ? nonce : priv;
    inv_t   = (c0 < 0) ? (c0 + $signed({2'b00, n_mod})) : c0;
    kinv_v  = (inv_t[N-1:0] == n_mod) ? '0 : inv_t[N-1:0];
    sd_sum  = {1'b0, rem} + {1'b0, n_mod} - {1'b0, b};
    sd_diff = (sd_sum >= {1'b0, n_mod}) ? N'(sd_sum - {1'b0, n_mod}) : sd_sum[N-1:0];
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      prime <= N'(PRIME_RESET);
      gen   <= N'(GENERATOR_RESET);
      priv  <= N'(PRIVATE_RESET);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PRIME:     prime <= cfg_data;
        REG_GENERATOR: gen   <= cfg_data;
        REG_PRIVATE:   priv  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ret       <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            msg   <= message_value;
            nonce <= nonce_value;
            n_mod <= prime - 1'b1;
            a     <= nonce_value;
            b     <= prime - 1'b1;
            if (prime < N'(2)) begin
              public_key     <= '0;
              sig_r          <= '0;
              sig_s          <= '0;
              nonce_rejected <= 1'b1;
              out_valid      <= 1'b1;
              state          <= S_OUT;
            end else begin
              state <= S_GCD;
            end
          end
        end
        // gcd(k, n) by repeated remainders
        S_GCD: begin
          if (b == '0) begin
            if (a == N'(1)) begin
              state <= S_INV_START;
            end else begin
              public_key     <= '0;
              sig_r          <= '0;
              sig_s          <= '0;
              nonce_rejected <= 1'b1;
              out_valid      <= 1'b1;
              state          <= S_OUT;
            end
          end else begin
            dvd   <= {{N{1'b0}}, a};
            dsr   <= b;
            ret   <= S_GCD_RET;
            state <= S_DIV_GO;
          end
        end
        S_GCD_RET: begin
          a     <= b;
          b     <= rem;
          state <= S_GCD;
        end
        // Extended Euclid for k^-1 mod n
        S_INV_START: begin
          if (n_mod == N'(1)) begin
            kinv  <= '0;
            sel_r <= 1'b0;
            state <= S_POW_START;
          end else begin
            dvd   <= {{N{1'b0}}, nonce};
            dsr   <= n_mod;
            ret   <= S_INV_R0;
            state <= S_DIV_GO;
          end
        end
        S_INV_R0: begin
          a     <= rem;
          b     <= n_mod;
          c0    <= (N+2)'(1);
          c1    <= '0;
          state <= S_INV_LOOP;
        end
        S_INV_LOOP: begin
          if (a > N'(1) && b != '0) begin
            dvd   <= {{N{1'b0}}, a};
            dsr   <= b;
            ret   <= S_INV_Q;
            state <= S_DIV_GO;
          end else begin
            state <= S_INV_FIN;
          end
        end
        S_INV_Q: begin
          sprod <= $signed({2'b00, quot[N-1:0]}) * c1;
          a     <= b;
          b     <= rem;
          state <= S_INV_UPD;
        end
        S_INV_UPD: begin
          c1    <= c0 - $signed(sprod[N+1:0]);
          c0    <= c1;
          state <= S_INV_LOOP;
        end
        S_INV_FIN: begin
          kinv  <= kinv_v;
          sel_r <= 1'b0;
          state <= S_POW_START;
        end
        // Square-and-multiply, first for y then for r
        S_POW_START: begin
          dvd   <= {{N{1'b0}}, gen};
          dsr   <= prime;
          ret   <= S_POW_B;
          state <= S_DIV_GO;
        end
        S_POW_B: begin
          base  <= rem;
          acc   <= N'(1);
          cnt   <= '0;
          state <= S_POW_STEP;
        end
        S_POW_STEP: begin
          if (cnt == CW'(N)) begin
            state <= S_POW_DONE;
          end else if (expo[cnt]) begin
            mul_a <= acc;
            mul_b <= base;
            dsr   <= prime;
            ret   <= S_POW_ACC;
            state <= S_MUL;
          end else begin
            state <= S_POW_SQ;
          end
        end
        S_POW_ACC: begin
          acc   <= rem;
          state <= S_POW_SQ;
        end
        S_POW_SQ: begin
          mul_a <= base;
          mul_b <= base;
          dsr   <= prime;
          ret   <= S_POW_BS;
          state <= S_MUL;
        end
        S_POW_BS: begin
          base  <= rem;
          cnt   <= cnt + 1'b1;
          state <= S_POW_STEP;
        end
        S_POW_DONE: begin
          if (!sel_r) begin
            public_key <= acc;
            sel_r      <= 1'b1;
            state      <= S_POW_START;
          end else begin
            sig_r <= acc;
            state <= S_XR0;
          end
        end
        // s = k^-1 * (m - x*r) mod n
        S_XR0: begin
          dvd   <= {{N{1'b0}}, priv};
          dsr   <= n_mod;
          ret   <= S_XR1;
          state <= S_DIV_GO;
        end
        S_XR1: begin
          a     <= rem;
          dvd   <= {{N{1'b0}}, sig_r};
          ret   <= S_XR2;
          state <= S_DIV_GO;
        end
        S_XR2: begin
          mul_a <= a;
          mul_b <= rem;
          ret   <= S_XR3;
          state <= S_MUL;
        end
        S_XR3: begin
          b     <= rem;
          dvd   <= {{N{1'b0}}, msg};
          ret   <= S_SD;
          state <= S_DIV_GO;
        end
        S_SD: begin
          mul_a <= kinv;
          mul_b <= sd_diff;
          ret   <= S_SF;
          state <= S_MUL;
        end
        S_SF: begin
          sig_s          <= rem;
          nonce_rejected <= 1'b0;
          out_valid      <= 1'b1;
          state          <= S_OUT;
        end
        // Shared multiply, then reduce
        S_MUL: begin
          dvd   <= mul_a * mul_b;
          state <= S_DIV_GO;
        end
        S_DIV_GO: begin
          state <= S_DIV_WAIT;
        end
        S_DIV_WAIT: begin
          if (div_stat.done) begin
            state <= ret;
          end
        end
        // Hold the result word until taken
        S_OUT: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign in_stall = (state != S_IDLE);

  a_out_state: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (state == S_OUT))
    else $error("result word shown outside the output state");

  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> (state == S_DIV_WAIT))
    else $error("divider finished with no waiting step");

  a_div_busy: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV_GO) |=> div_stat.busy)
    else $error("divider did not start");

  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && nonce_rejected) |-> (public_key == '0 && sig_r == '0 && sig_s == '0))
    else $error("rejected word carries nonzero values");

endmodule
